@@ rtl/kas_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kas_pkg
// Shared types and constants of the keyed attribute store: operation and
// status codes, hash constants, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package kas_pkg;

	localparam logic [1:0] OP_SET   = 2'd0;
	localparam logic [1:0] OP_GET   = 2'd1;
	localparam logic [1:0] OP_COPY  = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_SLOT_FULL = 2'd1;
	localparam logic [1:0] ST_POOL_FULL = 2'd2;
	localparam logic [1:0] ST_RESERVED  = 2'd3;

	localparam logic [63:0] MIX_C1    = 64'hff51afd7ed558ccd;
	localparam logic [63:0] MIX_C2    = 64'hc4ceb9fe1a85ec53;
	localparam int          MIX_SHIFT = 33;

	localparam int LOAD_NUM = 7;
	localparam int LOAD_DEN = 10;

	typedef enum logic [3:0] {
		H_IDLE, H_X1, H_A1, H_B1, H_C1, H_X2, H_A2, H_B2, H_C2, H_X3
	} kas_hstep_t;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_DISPATCH, S_HWAIT, S_PRD, S_PCHK, S_WRD, S_WCHK,
		S_SRD, S_SLATCH, S_THASH, S_TPROBE, S_DONE
	} kas_state_t;

	typedef enum logic [4:0] {
		A_NOP, A_CAPTURE, A_CLR_INIT, A_CLR_STEP, A_HASH_KEY, A_HASH_TGT,
		A_PROBE_HOME, A_PROBE_THOME, A_PROBE_NEXT, A_WALK_HEAD, A_WALK_NEXT,
		A_SRC_HEAD, A_SRC_LATCH, A_UPDATE, A_PREPEND, A_INSERT, A_GET_HIT,
		A_FAIL, A_FINISH
	} kas_act_t;

	typedef struct packed {
		kas_act_t   act;
		logic       tgt;
		logic       src;
		logic [1:0] code;
	} kas_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       key_zero;
		logic       tgt_zero;
		logic       hash_done;
		logic       slot_empty;
		logic       slot_match;
		logic       probe_last;
		logic       idx_end;
		logic       sym_hit;
		logic       src_end;
		logic       load_full;
		logic       pool_full;
		logic       clr_last;
		logic       out_free;
	} kas_stat_t;

endpackage
`default_nettype wire

@@ rtl/kas_hash.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kas_hash
// Iterative 64-bit mix finalizer. Each 64-bit multiply is split into three
// 32x32 partial products on one shared multiplier.
// ----------------------------------------------------------------------------
module kas_hash import kas_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] key,
	output logic             done,
	output logic [63:0]      hash
);

	kas_hstep_t  step_q;
	logic        done_q;
	logic [63:0] x_q;
	logic [63:0] acc_q;
	logic [63:0] k;
	logic [31:0] ma;
	logic [31:0] mb;
	logic [63:0] prod;
	logic        second;

	assign second = (step_q == H_A2) || (step_q == H_B2) || (step_q == H_C2);
	assign k      = second ? MIX_C2 : MIX_C1;
	assign ma     = ((step_q == H_B1) || (step_q == H_B2)) ? x_q[63:32] : x_q[31:0];
	assign mb     = ((step_q == H_C1) || (step_q == H_C2)) ? k[63:32] : k[31:0];
	assign prod   = {32'd0, ma} * {32'd0, mb};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= H_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (step_q)
				H_IDLE: if (start) step_q <= H_X1;
				H_X1:   step_q <= H_A1;
				H_A1:   step_q <= H_B1;
				H_B1:   step_q <= H_C1;
				H_C1:   step_q <= H_X2;
				H_X2:   step_q <= H_A2;
				H_A2:   step_q <= H_B2;
				H_B2:   step_q <= H_C2;
				H_C2:   step_q <= H_X3;
				H_X3: begin
					step_q <= H_IDLE;
					done_q <= 1'b1;
				end
				default: step_q <= H_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (step_q)
			H_IDLE: if (start) x_q <= key;
			H_X1, H_X2, H_X3: x_q <= x_q ^ (x_q >> MIX_SHIFT);
			H_A1, H_A2: acc_q <= prod;
			H_B1, H_B2: acc_q[63:32] <= acc_q[63:32] + prod[31:0];
			H_C1, H_C2: x_q <= {acc_q[63:32] + prod[31:0], acc_q[31:0]};
			default: x_q <= x_q;
		endcase
	end

	assign done = done_q;
	assign hash = x_q;

endmodule
`default_nettype wire

@@ rtl/kas_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kas_dp
// Datapath: captured item, slot and record memories, probe and chain
// pointers, counters and the result register, driven by controller commands.
// ----------------------------------------------------------------------------
module kas_dp import kas_pkg::*; #(
	parameter int SLOT_COUNT   = 1024,
	parameter int RECORD_COUNT = 4096
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire kas_cmd_t           cmd,
	output kas_stat_t               st,
	input  wire logic               cfg_wr_en,
	input  wire logic [63:0]        cfg_wr_data,
	input  wire logic [1:0]         operation,
	input  wire logic [63:0]        node_key,
	input  wire logic signed [63:0] symbol,
	input  wire logic [63:0]        attr_value,
	input  wire logic [63:0]        target_key,
	output logic [63:0]             result_word,
	output logic                    found,
	output logic [1:0]              status,
	output logic                    out_valid,
	input  wire logic               out_ready
);

	localparam int SW         = $clog2(SLOT_COUNT);
	localparam int UW         = SW + 1;
	localparam int LW         = $clog2(RECORD_COUNT) + 1;
	localparam int RW         = LW - 1;
	localparam int LOAD_LIMIT = (SLOT_COUNT * LOAD_NUM + LOAD_DEN - 1) / LOAD_DEN;

	logic [63:0] slot_key_mem [SLOT_COUNT];
	logic [LW-1:0] slot_head_mem [SLOT_COUNT];
	logic [63:0] rec_sym_mem [RECORD_COUNT];
	logic [63:0] rec_val_mem [RECORD_COUNT];
	logic [LW-1:0] rec_link_mem [RECORD_COUNT];

	logic [63:0] abs_q;
	logic [1:0]  op_q;
	logic [63:0] key_q, sym_q, val_q, tgt_q;
	logic [63:0] word_q;
	logic        found_q;
	logic [1:0]  status_q;
	logic [SW-1:0] probe_q, cnt_q, thome_q, clr_q;
	logic [LW-1:0] idx_q, src_q, head_q, cursor_q;
	logic [UW-1:0] used_q;
	logic [63:0] cp_sym_q, cp_val_q;
	logic [63:0] skey_rd_q;
	logic [LW-1:0] shead_rd_q;
	logic [63:0] rsym_rd_q, rval_rd_q;
	logic [LW-1:0] rlink_rd_q;
	logic        ov_q;
	logic [63:0] ow_q;
	logic        of_q;
	logic [1:0]  os_q;

	logic        hstart, hdone;
	logic [63:0] hkey, hres;
	logic [63:0] cur_key, cur_sym, cur_val;
	logic [LW-1:0] rd_idx;
	logic        out_free;
	logic        slot_wr, rec_new;
	logic [SW-1:0] slot_waddr;
	logic [63:0] slot_wdata;
	logic [LW-1:0] new_link;

	assign hstart = (cmd.act == A_HASH_KEY) || (cmd.act == A_HASH_TGT);
	assign hkey   = (cmd.act == A_HASH_TGT) ? tgt_q : key_q;

	kas_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hstart),
		.key    (hkey),
		.done   (hdone),
		.hash   (hres)
	);

	assign cur_key  = cmd.tgt ? tgt_q : key_q;
	assign cur_sym  = cmd.tgt ? cp_sym_q : sym_q;
	assign cur_val  = cmd.tgt ? cp_val_q : val_q;
	assign rd_idx   = cmd.src ? src_q : idx_q;
	assign out_free = !ov_q || out_ready;

	assign slot_wr    = (cmd.act == A_CLR_STEP) || (cmd.act == A_INSERT);
	assign slot_waddr = (cmd.act == A_CLR_STEP) ? clr_q : probe_q;
	assign slot_wdata = (cmd.act == A_CLR_STEP) ? 64'd0 : cur_key;
	assign rec_new    = (cmd.act == A_PREPEND) || (cmd.act == A_INSERT);
	assign new_link   = (cmd.act == A_INSERT) ? LW'(RECORD_COUNT) : head_q;

	always_ff @(posedge clk) begin
		if (slot_wr) slot_key_mem[slot_waddr] <= slot_wdata;
		skey_rd_q <= slot_key_mem[probe_q];
	end

	always_ff @(posedge clk) begin
		if (rec_new) slot_head_mem[probe_q] <= cursor_q;
		shead_rd_q <= slot_head_mem[probe_q];
	end

	always_ff @(posedge clk) begin
		if (rec_new) begin
			rec_sym_mem[cursor_q[RW-1:0]]  <= cur_sym;
			rec_link_mem[cursor_q[RW-1:0]] <= new_link;
		end
		rsym_rd_q  <= rec_sym_mem[rd_idx[RW-1:0]];
		rlink_rd_q <= rec_link_mem[rd_idx[RW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (rec_new) rec_val_mem[cursor_q[RW-1:0]] <= cur_val;
		else if (cmd.act == A_UPDATE) rec_val_mem[idx_q[RW-1:0]] <= cur_val;
		rval_rd_q <= rec_val_mem[rd_idx[RW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			abs_q    <= 64'd0;
			clr_q    <= '0;
			used_q   <= '0;
			cursor_q <= '0;
			ov_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) abs_q <= cfg_wr_data;
			if (cmd.act == A_CLR_INIT) begin
				used_q   <= '0;
				cursor_q <= '0;
			end
			if (cmd.act == A_CLR_STEP) clr_q <= clr_q + 1'b1;
			if (rec_new) cursor_q <= cursor_q + 1'b1;
			if (cmd.act == A_INSERT) used_q <= used_q + 1'b1;
			if (cmd.act == A_FINISH) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.act)
			A_CAPTURE: begin
				op_q     <= operation;
				key_q    <= node_key;
				sym_q    <= $unsigned(symbol);
				val_q    <= attr_value;
				tgt_q    <= target_key;
				found_q  <= 1'b0;
				status_q <= ST_OK;
				case (operation)
					OP_SET:  word_q <= attr_value;
					OP_GET:  word_q <= abs_q;
					OP_COPY: word_q <= target_key;
					default: word_q <= 64'd0;
				endcase
			end
			A_PROBE_HOME: begin
				probe_q <= hres[SW-1:0];
				cnt_q   <= '0;
				if (cmd.tgt) thome_q <= hres[SW-1:0];
			end
			A_PROBE_THOME: begin
				probe_q <= thome_q;
				cnt_q   <= '0;
			end
			A_PROBE_NEXT: begin
				probe_q <= probe_q + 1'b1;
				cnt_q   <= cnt_q + 1'b1;
			end
			A_WALK_HEAD: begin
				idx_q  <= shead_rd_q;
				head_q <= shead_rd_q;
			end
			A_WALK_NEXT: idx_q <= rlink_rd_q;
			A_SRC_HEAD: begin
				src_q   <= shead_rd_q;
				found_q <= 1'b1;
			end
			A_SRC_LATCH: begin
				cp_sym_q <= rsym_rd_q;
				cp_val_q <= rval_rd_q;
				src_q    <= rlink_rd_q;
			end
			A_GET_HIT: begin
				word_q  <= rval_rd_q;
				found_q <= 1'b1;
			end
			A_FAIL: status_q <= cmd.code;
			default: op_q <= op_q;
		endcase
		if (cmd.act == A_FINISH) begin
			ow_q <= word_q;
			of_q <= found_q;
			os_q <= status_q;
		end
	end

	always_comb begin
		st.op         = op_q;
		st.key_zero   = (key_q == 64'd0);
		st.tgt_zero   = (tgt_q == 64'd0);
		st.hash_done  = hdone;
		st.slot_empty = (skey_rd_q == 64'd0);
		st.slot_match = (skey_rd_q == cur_key);
		st.probe_last = (cnt_q == SW'(SLOT_COUNT - 1));
		st.idx_end    = (idx_q >= cursor_q);
		st.sym_hit    = (rsym_rd_q == cur_sym);
		st.src_end    = (src_q >= cursor_q);
		st.load_full  = (used_q >= UW'(LOAD_LIMIT - 1));
		st.pool_full  = (cursor_q == LW'(RECORD_COUNT));
		st.clr_last   = (clr_q == SW'(SLOT_COUNT - 1));
		st.out_free   = out_free;
	end

	assign result_word = ow_q;
	assign found       = of_q;
	assign status      = os_q;
	assign out_valid   = ov_q;

endmodule
`default_nettype wire

@@ rtl/kas_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kas_ctrl
// Controller: sequences hashing, linear probing, chain walks, copy replay,
// table clearing and result hand-off by issuing datapath commands.
// ----------------------------------------------------------------------------
module kas_ctrl import kas_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire kas_stat_t st,
	output kas_cmd_t       cmd
);

	kas_state_t state_q, state_d;
	logic       tphase_q;
	logic       boot_q;
	logic       set_mode;
	logic       get_mode;
	kas_state_t ok_next;

	assign set_mode = (st.op == OP_SET) || tphase_q;
	assign get_mode = (st.op == OP_GET);
	assign ok_next  = tphase_q ? S_SRD : S_DONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			tphase_q <= 1'b0;
			boot_q   <= 1'b1;
		end else begin
			state_q <= state_d;
			if (state_q == S_DISPATCH) tphase_q <= 1'b0;
			if (state_q == S_SLATCH) tphase_q <= 1'b1;
			if (state_q == S_CLEAR && st.clr_last) boot_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (st.clr_last) state_d = boot_q ? S_IDLE : S_DONE;
			S_IDLE: if (in_valid) state_d = S_DISPATCH;
			S_DISPATCH: begin
				if (st.op == OP_CLEAR) state_d = S_CLEAR;
				else if (st.key_zero || (st.op == OP_COPY && st.tgt_zero)) state_d = S_DONE;
				else state_d = S_HWAIT;
			end
			S_HWAIT: if (st.hash_done) state_d = S_PRD;
			S_PRD: state_d = S_PCHK;
			S_PCHK: begin
				if (st.slot_empty || (!st.slot_match && st.probe_last)) begin
					if (!set_mode) state_d = S_DONE;
					else if (st.slot_empty && !st.load_full && !st.pool_full)
						state_d = ok_next;
					else state_d = S_DONE;
				end else if (st.slot_match) begin
					state_d = (set_mode || get_mode) ? S_WRD : S_SRD;
				end else begin
					state_d = S_PRD;
				end
			end
			S_WRD: begin
				if (!st.idx_end) state_d = S_WCHK;
				else if (get_mode && !tphase_q) state_d = S_DONE;
				else if (st.pool_full) state_d = S_DONE;
				else state_d = ok_next;
			end
			S_WCHK: begin
				if (!st.sym_hit) state_d = S_WRD;
				else if (get_mode && !tphase_q) state_d = S_DONE;
				else state_d = ok_next;
			end
			S_SRD: state_d = st.src_end ? S_DONE : S_SLATCH;
			S_SLATCH: state_d = tphase_q ? S_TPROBE : S_THASH;
			S_THASH: state_d = S_HWAIT;
			S_TPROBE: state_d = S_PRD;
			S_DONE: if (st.out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.act  = A_NOP;
		cmd.tgt  = tphase_q;
		cmd.src  = (state_q == S_SRD);
		cmd.code = ST_OK;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR: cmd.act = A_CLR_STEP;
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.act = A_CAPTURE;
			end
			S_DISPATCH: begin
				if (st.op == OP_CLEAR) cmd.act = A_CLR_INIT;
				else if (st.key_zero || (st.op == OP_COPY && st.tgt_zero)) begin
					cmd.act  = A_FAIL;
					cmd.code = ST_RESERVED;
				end else cmd.act = A_HASH_KEY;
			end
			S_HWAIT: if (st.hash_done) cmd.act = A_PROBE_HOME;
			S_PCHK: begin
				if (st.slot_empty || (!st.slot_match && st.probe_last)) begin
					if (set_mode) begin
						if (!st.slot_empty || st.load_full) begin
							cmd.act  = A_FAIL;
							cmd.code = ST_SLOT_FULL;
						end else if (st.pool_full) begin
							cmd.act  = A_FAIL;
							cmd.code = ST_POOL_FULL;
						end else cmd.act = A_INSERT;
					end
				end else if (st.slot_match) begin
					cmd.act = (set_mode || get_mode) ? A_WALK_HEAD : A_SRC_HEAD;
				end else cmd.act = A_PROBE_NEXT;
			end
			S_WRD: begin
				if (st.idx_end && !(get_mode && !tphase_q)) begin
					if (st.pool_full) begin
						cmd.act  = A_FAIL;
						cmd.code = ST_POOL_FULL;
					end else cmd.act = A_PREPEND;
				end
			end
			S_WCHK: begin
				if (!st.sym_hit) cmd.act = A_WALK_NEXT;
				else if (get_mode && !tphase_q) cmd.act = A_GET_HIT;
				else cmd.act = A_UPDATE;
			end
			S_SLATCH: cmd.act = A_SRC_LATCH;
			S_THASH: cmd.act = A_HASH_TGT;
			S_TPROBE: cmd.act = A_PROBE_THOME;
			S_DONE: if (st.out_free) cmd.act = A_FINISH;
			default: cmd.act = A_NOP;
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/keyed_attribute_store_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_attribute_store_unit
// Fixed-size store of (key, symbol) attributes: a linearly probed slot table
// whose slots head newest-first record chains in a record pool.
//
//   Port group    Direction  Handshake              Contents
//   in_*          in         in_valid / in_ready    operation, keys, symbol, value
//   out_*         out        out_valid / out_ready  result_word, found, status
//   cfg_*         in         cfg_wr_en              absent value word
//
// One item is in work at a time. A copy adds a hash of the target plus one
// full set per replayed record. Clear empties every slot and the record pool.
// After reset a sweep empties the slot table while in_ready stays low. A
// result waits in the output register while out_ready is low; the next beat
// is accepted once it has been loaded there.
// ----------------------------------------------------------------------------
module keyed_attribute_store_unit import kas_pkg::*; #(
	parameter int SLOT_COUNT   = 1024,
	parameter int RECORD_COUNT = 4096
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [63:0]        cfg_wr_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         operation,
	input  wire logic [63:0]        node_key,
	input  wire logic signed [63:0] symbol,
	input  wire logic [63:0]        attr_value,
	input  wire logic [63:0]        target_key,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [63:0]             result_word,
	output logic                    found,
	output logic [1:0]              status
);

	kas_cmd_t  cmd;
	kas_stat_t st;

	kas_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	kas_dp #(
		.SLOT_COUNT   (SLOT_COUNT),
		.RECORD_COUNT (RECORD_COUNT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.operation   (operation),
		.node_key    (node_key),
		.symbol      (symbol),
		.attr_value  (attr_value),
		.target_key  (target_key),
		.result_word (result_word),
		.found       (found),
		.status      (status),
		.out_valid   (out_valid),
		.out_ready   (out_ready)
	);

endmodule
`default_nettype wire

@@ rtl/kas_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kas_checker
// Port-level checks of the keyed attribute store, bound to the top level.
// ----------------------------------------------------------------------------
module kas_checker import kas_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [63:0]        result_word,
	input wire logic               found,
	input wire logic [1:0]         status
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_word) && $stable(status))
		else $error("Result beat changed while stalled.");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("Second beat taken while an item was in work.");

	a_reserved_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> status != ST_RESERVED)
		else $error("Reserved key reported as found.");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("Result appeared without any work cycle.");

endmodule

bind keyed_attribute_store_unit kas_checker u_kas_checker (.*);
`default_nettype wire
